[hw/rtl/rsd_pkg.sv]
package rsd_pkg;

	localparam int CFG_W     = 32;
	localparam int NUM_CFG   = 7;
	localparam int CFG_IDX_W = 3;
	localparam int TOKEN_W   = 64;
	localparam int FLAGS_W   = 12;

	typedef enum logic [2:0] {
		CFG_PARK_MS      = 3'd0,
		CFG_PARK_HINT_MS = 3'd1,
		CFG_OFF_MS       = 3'd2,
		CFG_OFF_WEAK_MS  = 3'd3,
		CFG_OFF_CM       = 3'd4,
		CFG_OFF_WEAK_CM  = 3'd5,
		CFG_HINT_HOLD_MS = 3'd6
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
		32'd60000, 32'd20000, 32'd20000, 32'd10000, 32'd10000, 32'd5000, 32'd30000
	};

	typedef enum logic [1:0] {
		OP_UPDATE  = 2'd0,
		OP_RESET   = 2'd1,
		OP_RESTORE = 2'd2,
		OP_ARM     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_UNSNAPPED = 2'd0,
		ST_ROAD      = 2'd1,
		ST_PARKING   = 2'd2,
		ST_OFFROAD   = 2'd3
	} st_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_USE     = 3'd1,
		ACT_HOLD    = 3'd2,
		ACT_PARK    = 3'd3,
		ACT_OFFROAD = 3'd4
	} act_t;

	localparam logic [1:0] ACC_MODERATE = 2'd1;
	localparam logic [1:0] ACC_POOR     = 2'd2;

	localparam logic [2:0] REL_SAME_EDGE = 3'd0;
	localparam logic [2:0] REL_SAME_ROAD = 3'd1;
	localparam logic [2:0] REL_CONNECTED = 3'd2;
	localparam logic [2:0] REL_REVERSE   = 3'd3;

	// evidence flag bit positions
	localparam int F_ENTRANCE   = 0;
	localparam int F_PARK_OK    = 1;
	localparam int F_OFFROAD    = 2;
	localparam int F_REACQUIRE  = 3;
	localparam int F_ACCEPTABLE = 4;
	localparam int F_UNAMBIG    = 5;
	localparam int F_WEAK       = 6;
	localparam int F_HAS_BEST   = 7;
	localparam int F_STRONG     = 8;
	localparam int F_STATIONARY = 9;
	localparam int F_MOTION     = 10;
	localparam int F_BEATS      = 11;

	typedef struct packed {
		logic [TOKEN_W-1:0] tok;
		logic [1:0]         cnt;
		logic               fire;
	} pend_t;

	function automatic logic [CFG_W-1:0] sat_add(input logic [CFG_W-1:0] a,
			input logic [15:0] b);
		logic [CFG_W:0] s;
		s = {1'b0, a} + {{(CFG_W-15){1'b0}}, b};
		return s[CFG_W] ? {CFG_W{1'b1}} : s[CFG_W-1:0];
	endfunction

endpackage

[hw/rtl/rsd_if.sv]
interface rsd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] delta_ms;
	logic [15:0] raw_step_cm;
	logic [63:0] candidate_token;
	logic [1:0]  accuracy;
	logic [2:0]  relation;
	logic [11:0] evidence_flags;
	logic [1:0]  restore_state;

	modport source(output valid, op, delta_ms, raw_step_cm, candidate_token, accuracy,
		relation, evidence_flags, restore_state, input ready);
	modport sink(input valid, op, delta_ms, raw_step_cm, candidate_token, accuracy,
		relation, evidence_flags, restore_state, output ready);
endinterface

interface rsd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [1:0] match_state;
	logic       state_changed;

	modport source(output valid, action, match_state, state_changed, input ready);
	modport sink(input valid, action, match_state, state_changed, output ready);
endinterface

[hw/rtl/road_snap_decision_fsm.sv]
// Road snap decision machine. Each word on upd is an op (update, reset, restore a free
// state, arm the restore hint) and yields exactly one result word on res: the action,
// the match state after the op and a changed flag. A word is registered on entry, then
// decided combinationally against the held state and its result registered, so one word is
// taken every cycle unless res stalls; throughput is set only by the result register, which
// stalls the entry register when it holds a result and res.ready is low. The seven threshold
// registers are written through cfg_we/cfg_idx/cfg_wdata; the user must do so only while
// idle, which the block itself does not enforce. Indexes beyond the list are ignored.
module road_snap_decision_fsm
	import rsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	rsd_in_if.sink               upd,
	rsd_out_if.source            res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [CFG_W-1:0] cfg_q [NUM_CFG];

	// entry register
	logic               valid_s1;
	op_t                op_s1;
	logic [15:0]        dt_s1;
	logic [15:0]        step_s1;
	logic [TOKEN_W-1:0] tok_s1;
	logic [1:0]         acc_s1;
	logic [2:0]         rel_s1;
	logic [FLAGS_W-1:0] f_s1;
	logic [1:0]         rs_s1;

	// decision state
	st_t                state_q;
	logic [TOKEN_W-1:0] pend_tok_q;
	logic [1:0]         pend_cnt_q;
	logic [CFG_W-1:0]   park_acc_q, off_t_q, off_d_q, hint_q;
	logic               restore_hint_q;

	// result register
	logic out_valid_q;
	act_t act_q;
	st_t  out_st_q;
	logic changed_q;

	logic fire;
	assign fire     = valid_s1 && (!out_valid_q || res.ready);
	assign upd.ready = !valid_s1 || fire;

	// next-state values
	st_t                st_n;
	act_t               act_n;
	logic [TOKEN_W-1:0] pend_tok_n;
	logic [1:0]         pend_cnt_n;
	logic [CFG_W-1:0]   park_acc_n, off_t_n, off_d_n, hint_n;
	logic               restore_hint_n;

	logic             acc_ok, unamb, park_ready, off_ready, free_st;
	logic [1:0]       need, need_sel;
	logic [CFG_W-1:0] park_need, off_t_need, off_d_need;
	pend_t            pa;

	always_comb begin
		acc_ok  = acc_s1 < ACC_POOR;
		unamb   = f_s1[F_UNAMBIG];
		need    = (acc_s1 == ACC_MODERATE) ? 2'd3 : 2'd2;
		free_st = (state_q == ST_PARKING) || (state_q == ST_OFFROAD);

		if (free_st)
			need_sel = need;
		else if (state_q == ST_UNSNAPPED)
			need_sel = (restore_hint_q && f_s1[F_STRONG]) ? 2'd1 : need;
		else if (rel_s1 == REL_REVERSE)
			need_sel = 2'd2;
		else
			need_sel = need;

		// one shared pending-candidate step
		pa.tok  = pend_tok_q;
		pa.cnt  = pend_cnt_q;
		pa.fire = 1'b0;
		if (tok_s1 == '0) begin
			pa.tok = '0;
			pa.cnt = 2'd0;
		end else begin
			if (pend_tok_q != tok_s1) begin
				pa.tok = tok_s1;
				pa.cnt = 2'd1;
			end else if (pend_cnt_q != 2'd3) begin
				pa.cnt = pend_cnt_q + 2'd1;
			end
			if (pa.cnt >= need_sel) begin
				pa.fire = 1'b1;
				pa.tok  = '0;
				pa.cnt  = 2'd0;
			end
		end

		// accumulators and hint countdown
		if (f_s1[F_ENTRANCE])
			hint_n = cfg_q[CFG_HINT_HOLD_MS];
		else
			hint_n = (hint_q > {16'd0, dt_s1}) ? hint_q - {16'd0, dt_s1} : '0;
		park_acc_n = f_s1[F_PARK_OK] ? sat_add(park_acc_q, dt_s1) : '0;
		off_t_n    = f_s1[F_OFFROAD] ? sat_add(off_t_q, dt_s1) : '0;
		off_d_n    = f_s1[F_OFFROAD] ? sat_add(off_d_q, step_s1) : '0;

		park_need  = (hint_n != '0) ? cfg_q[CFG_PARK_HINT_MS] : cfg_q[CFG_PARK_MS];
		off_t_need = f_s1[F_WEAK] ? cfg_q[CFG_OFF_WEAK_MS] : cfg_q[CFG_OFF_MS];
		off_d_need = f_s1[F_WEAK] ? cfg_q[CFG_OFF_WEAK_CM] : cfg_q[CFG_OFF_CM];
		park_ready = f_s1[F_PARK_OK] && (park_acc_n >= park_need);
		off_ready  = f_s1[F_OFFROAD] && (off_t_n >= off_t_need) && (off_d_n >= off_d_need);

		st_n           = state_q;
		act_n          = ACT_NONE;
		pend_tok_n     = '0;
		pend_cnt_n     = 2'd0;
		restore_hint_n = restore_hint_q;

		case (op_s1)
			OP_UPDATE: begin
				if (free_st) begin
					if (f_s1[F_REACQUIRE] && f_s1[F_ACCEPTABLE] && unamb && acc_ok) begin
						pend_tok_n = pa.tok;
						pend_cnt_n = pa.cnt;
						if (pa.fire) begin
							park_acc_n = '0;
							off_t_n    = '0;
							off_d_n    = '0;
							st_n       = ST_ROAD;
							act_n      = ACT_USE;
						end
					end else if (state_q == ST_OFFROAD && park_ready) begin
						st_n  = ST_PARKING;
						act_n = ACT_PARK;
					end else if (state_q == ST_PARKING && off_ready) begin
						st_n  = ST_OFFROAD;
						act_n = ACT_OFFROAD;
					end
				end else if (park_ready) begin
					off_t_n = '0;
					off_d_n = '0;
					st_n    = ST_PARKING;
					act_n   = ACT_PARK;
				end else if (off_ready) begin
					park_acc_n = '0;
					st_n       = ST_OFFROAD;
					act_n      = ACT_OFFROAD;
				end else if (state_q == ST_UNSNAPPED) begin
					if (f_s1[F_HAS_BEST] && f_s1[F_ACCEPTABLE] && unamb && acc_ok) begin
						pend_tok_n = pa.tok;
						pend_cnt_n = pa.cnt;
						if (pa.fire) begin
							restore_hint_n = 1'b0;
							st_n           = ST_ROAD;
							act_n          = ACT_USE;
						end
					end
				end else if (!f_s1[F_ACCEPTABLE]) begin
					act_n = ACT_HOLD;
				end else if (rel_s1 inside {REL_SAME_EDGE, REL_SAME_ROAD}) begin
					act_n = ACT_USE;
				end else if (f_s1[F_STATIONARY]) begin
					act_n = ACT_HOLD;
				end else if (rel_s1 == REL_CONNECTED) begin
					act_n = (f_s1[F_MOTION] && unamb && acc_ok) ? ACT_USE : ACT_HOLD;
				end else if (rel_s1 == REL_REVERSE) begin
					act_n = ACT_HOLD;
					if (f_s1[F_MOTION] && unamb && acc_ok) begin
						pend_tok_n = pa.tok;
						pend_cnt_n = pa.cnt;
						act_n      = pa.fire ? ACT_USE : ACT_HOLD;
					end
				end else begin
					// other relation codes, including the unused ones
					act_n = ACT_HOLD;
					if (unamb && f_s1[F_BEATS] && acc_ok) begin
						pend_tok_n = pa.tok;
						pend_cnt_n = pa.cnt;
						act_n      = pa.fire ? ACT_USE : ACT_HOLD;
					end
				end
			end
			OP_RESET, OP_RESTORE: begin
				st_n           = ST_UNSNAPPED;
				park_acc_n     = '0;
				off_t_n        = '0;
				off_d_n        = '0;
				hint_n         = '0;
				restore_hint_n = 1'b0;
				if (op_s1 == OP_RESTORE && (rs_s1 inside {ST_PARKING, ST_OFFROAD}))
					st_n = st_t'(rs_s1);
			end
			OP_ARM: begin
				pend_tok_n     = pend_tok_q;
				pend_cnt_n     = pend_cnt_q;
				park_acc_n     = park_acc_q;
				off_t_n        = off_t_q;
				off_d_n        = off_d_q;
				hint_n         = hint_q;
				restore_hint_n = 1'b1;
			end
			default: begin
				st_n = state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++)
				cfg_q[i] <= CFG_RESET[i];
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_CFG; i++)
				if (cfg_idx == CFG_IDX_W'(i))
					cfg_q[i] <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (upd.ready)
			valid_s1 <= upd.valid;
	end

	always_ff @(posedge clk) begin
		if (upd.valid && upd.ready) begin
			op_s1   <= op_t'(upd.op);
			dt_s1   <= upd.delta_ms;
			step_s1 <= upd.raw_step_cm;
			tok_s1  <= upd.candidate_token;
			acc_s1  <= upd.accuracy;
			rel_s1  <= upd.relation;
			f_s1    <= upd.evidence_flags;
			rs_s1   <= upd.restore_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_UNSNAPPED;
			pend_tok_q     <= '0;
			pend_cnt_q     <= 2'd0;
			park_acc_q     <= '0;
			off_t_q        <= '0;
			off_d_q        <= '0;
			hint_q         <= '0;
			restore_hint_q <= 1'b0;
		end else if (fire) begin
			state_q        <= st_n;
			pend_tok_q     <= pend_tok_n;
			pend_cnt_q     <= pend_cnt_n;
			park_acc_q     <= park_acc_n;
			off_t_q        <= off_t_n;
			off_d_q        <= off_d_n;
			hint_q         <= hint_n;
			restore_hint_q <= restore_hint_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			act_q     <= act_n;
			out_st_q  <= st_n;
			changed_q <= (st_n != state_q);
		end
	end

	assign res.valid         = out_valid_q;
	assign res.action        = act_q;
	assign res.match_state   = out_st_q;
	assign res.state_changed = changed_q;

	// a pending candidate always has a nonzero token and a count
	a_pend_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_cnt_q == 2'd0) == (pend_tok_q == '0))
		else $error("pending token and count disagree");

	// a count of three always fires and clears
	a_pend_below_three: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q != 2'd3)
		else $error("pending count left at three");

	a_park_action_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && act_q == ACT_PARK |-> out_st_q == ST_PARKING)
		else $error("enter parking without parking state");

	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_s1 == OP_RESET |=> park_acc_q == '0 && hint_q == '0 &&
			state_q == ST_UNSNAPPED && !restore_hint_q)
		else $error("reset op left state behind");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !res.ready |-> !upd.ready)
		else $error("entry taken while result stalled");

endmodule
